### rtl/pcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared constants, codes and controller/datapath interface types for the
// per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

    // Default sizing
    localparam int CPU_COUNT_DEF  = 8;
    localparam int MAX_PAGES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 4096;

    // Fixed field widths
    localparam int ADDR_W   = 32;
    localparam int CPU_IN_W = 3;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 3;

    // Operation codes
    localparam logic FUNC_FREE  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Register word indexes
    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_TOP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FREED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OWN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STOLEN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OOM     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic                load;       // capture request fields
        logic                calc_fp;    // round pool base up to first page
        logic                chk1;       // alignment and window checks
        logic                chk2;       // offset from first page
        logic                scan_clr;   // restart steal scan at CPU 0
        logic                scan_step;  // advance steal scan
        logic                take_scan;  // victim list is the scanned one
        logic                head_rd;    // read victim list head
        logic                link_rd;    // read link of head page
        logic                pop_wr;     // unlink head page
        logic                push_wr;    // link freed page in
        logic                out_en;     // present a result
        logic [STATUS_W-1:0] out_status;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_alloc;
        logic own_ne;
        logic scan_hit;
        logic scan_last;
        logic free_ok;
    } t_sts;

endpackage

### rtl/pcpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pcpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_ctrl
// Request sequencer: checks and pushes frees, pops allocs, scans the other
// CPUs one per cycle when the own list is empty.
// ----------------------------------------------------------------------------
module pcpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pcpa_pkg::t_sts  i_sts,
    output pcpa_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    import pcpa_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_BASE = 10'b00_0000_0010,
        S_SEL  = 10'b00_0000_0100,
        S_SCAN = 10'b00_0000_1000,
        S_AHR  = 10'b00_0001_0000,
        S_AHD  = 10'b00_0010_0000,
        S_ALD  = 10'b00_0100_0000,
        S_CHK1 = 10'b00_1000_0000,
        S_CHK2 = 10'b01_0000_0000,
        S_CHK3 = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_stolen, n_stolen;
    t_cmd   w_cmd;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_stolen = r_stolen;
        w_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_stolen   = 1'b0;
                    n_state    = S_BASE;
                end
            end
            S_BASE: begin
                w_cmd.calc_fp = 1'b1;
                n_state       = i_sts.is_alloc ? S_SEL : S_CHK1;
            end
            S_SEL: begin
                if (i_sts.own_ne) begin
                    n_state = S_AHR;
                end else begin
                    w_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    w_cmd.take_scan = 1'b1;
                    n_stolen        = 1'b1;
                    n_state         = S_AHR;
                end else if (i_sts.scan_last) begin
                    w_cmd.out_en     = 1'b1;
                    w_cmd.out_status = ST_OOM;
                    n_state          = S_IDLE;
                end else begin
                    w_cmd.scan_step = 1'b1;
                end
            end
            S_AHR: begin
                w_cmd.head_rd = 1'b1;
                n_state       = S_AHD;
            end
            S_AHD: begin
                w_cmd.link_rd = 1'b1;
                n_state       = S_ALD;
            end
            S_ALD: begin
                w_cmd.pop_wr     = 1'b1;
                w_cmd.out_en     = 1'b1;
                w_cmd.out_status = r_stolen ? ST_STOLEN : ST_OWN;
                n_state          = S_IDLE;
            end
            S_CHK1: begin
                w_cmd.chk1 = 1'b1;
                n_state    = S_CHK2;
            end
            S_CHK2: begin
                w_cmd.chk2 = 1'b1;
                n_state    = S_CHK3;
            end
            S_CHK3: begin
                if (i_sts.free_ok) begin
                    w_cmd.head_rd = 1'b1;
                    n_state       = S_ALD;
                end else begin
                    w_cmd.out_en     = 1'b1;
                    w_cmd.out_status = ST_BADFREE;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // free completes in the shared final state with a push instead
        if (r_state == S_ALD && !i_sts.is_alloc) begin
            w_cmd.pop_wr     = 1'b0;
            w_cmd.push_wr    = 1'b1;
            w_cmd.out_status = ST_FREED;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stolen <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stolen <= n_stolen;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

### rtl/pcpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_dp
// Allocator datapath: pool registers, address checks, list-head and link
// memories, per-CPU non-empty flags, steal scan counter and result register.
// ----------------------------------------------------------------------------
module pcpa_dp #(
    parameter int CPU_COUNT  = pcpa_pkg::CPU_COUNT_DEF,
    parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcpa_pkg::t_cmd                  i_cmd,
    output pcpa_pkg::t_sts                  o_sts,
    input  logic                            i_func,
    input  logic [pcpa_pkg::CPU_IN_W-1:0]   i_requester_cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]     i_page_address,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [pcpa_pkg::ADDR_W-1:0]     i_cfg_wdata,
    output logic [pcpa_pkg::ADDR_W-1:0]     o_cfg_rdata,
    output logic                            o_valid,
    output logic [pcpa_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [pcpa_pkg::STATUS_W-1:0]   o_status
);

    import pcpa_pkg::*;

    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int IW = $clog2(MAX_PAGES);
    localparam int HW = $clog2(MAX_PAGES + 1);
    localparam int PB = $clog2(PAGE_BYTES);
    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'(PAGE_BYTES - 1);

    // Pool registers
    logic [ADDR_W-1:0]   r_pool_base, r_pool_top;
    // Request capture and check state
    logic                r_func;
    logic [CW-1:0]       r_cpu, r_victim, r_scan;
    logic [ADDR_W-1:0]   r_pa, r_diff, r_grant;
    logic [ADDR_W:0]     r_fp;
    logic                r_ok;
    logic [CPU_COUNT-1:0] r_nonempty;
    // Result register
    logic                r_valid;
    logic [ADDR_W-1:0]   r_granted;
    logic [STATUS_W-1:0] r_status;

    logic [CPU_IN_W-1:0] w_cpu_mod;
    logic [ADDR_W:0]     w_fp, w_sub, w_idx_ext;
    logic                w_in_range;
    logic [IW-1:0]       w_idx, w_head_idx;
    logic [HW-1:0]       w_head_rdata, w_link_rdata, w_head_wdata, w_link_wdata;

    // Requester index folded into the CPU range
    always_comb begin
        w_cpu_mod = i_requester_cpu;
        for (int k = 0; k < 7; k++) begin
            if (int'(w_cpu_mod) >= CPU_COUNT) begin
                w_cpu_mod = w_cpu_mod - CPU_IN_W'(CPU_COUNT);
            end
        end
    end

    // Address arithmetic
    assign w_fp       = ({1'b0, r_pool_base} + PAGE_MASK) & ~PAGE_MASK;
    assign w_sub      = {1'b0, r_pa} - r_fp;
    assign w_idx_ext  = (ADDR_W + 1)'(r_diff >> PB);
    assign w_in_range = w_idx_ext < (ADDR_W + 1)'(MAX_PAGES);
    assign w_idx      = w_idx_ext[IW-1:0];
    assign w_head_idx = IW'(w_head_rdata - HW'(1));

    // Memory write data
    assign w_head_wdata = i_cmd.push_wr ? (HW'(w_idx) + HW'(1)) : w_link_rdata;
    assign w_link_wdata = r_nonempty[r_victim] ? w_head_rdata : '0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
            r_pool_top  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_POOL_TOP) begin
                r_pool_top <= i_cfg_wdata;
            end else begin
                r_pool_base <= i_cfg_wdata;
            end
        end
    end

    assign o_cfg_rdata = (i_cfg_addr == REG_POOL_TOP) ? r_pool_top : r_pool_base;

    // Request capture, checks, scan and address build
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_cpu    <= CW'(w_cpu_mod);
            r_victim <= CW'(w_cpu_mod);
            r_pa     <= i_page_address;
        end
        if (i_cmd.calc_fp) begin
            r_fp <= w_fp;
        end
        if (i_cmd.chk1) begin
            r_ok <= !r_fp[ADDR_W]
                 && ((r_pa & PAGE_MASK[ADDR_W-1:0]) == '0)
                 && (r_pa >= r_pool_base)
                 && (r_pa < r_pool_top);
        end
        if (i_cmd.chk2) begin
            r_ok   <= r_ok && !w_sub[ADDR_W];
            r_diff <= w_sub[ADDR_W-1:0];
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + CW'(1);
        end
        if (i_cmd.take_scan) begin
            r_victim <= r_scan;
        end
        if (i_cmd.link_rd) begin
            r_grant <= r_fp[ADDR_W-1:0] + (ADDR_W'(w_head_idx) << PB);
        end
    end

    // Per-CPU non-empty flags, stand in for head reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
        end else if (i_cmd.push_wr) begin
            r_nonempty[r_victim] <= 1'b1;
        end else if (i_cmd.pop_wr) begin
            r_nonempty[r_victim] <= |w_link_rdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_status  <= i_cmd.out_status;
            r_granted <= i_cmd.pop_wr ? r_grant : '0;
        end
    end

    // List heads, one per CPU
    pcpa_ram #(
        .WIDTH (HW),
        .DEPTH (CPU_COUNT),
        .AW    (CW)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pop_wr | i_cmd.push_wr),
        .i_waddr (r_victim),
        .i_wdata (w_head_wdata),
        .i_re    (i_cmd.head_rd),
        .i_raddr (r_victim),
        .o_rdata (w_head_rdata)
    );

    // Next-page links, one per page
    pcpa_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_PAGES),
        .AW    (IW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_wr),
        .i_waddr (w_idx),
        .i_wdata (w_link_wdata),
        .i_re    (i_cmd.link_rd),
        .i_raddr (w_head_idx),
        .o_rdata (w_link_rdata)
    );

    // Status to controller
    assign o_sts.is_alloc  = (r_func == FUNC_ALLOC);
    assign o_sts.own_ne    = r_nonempty[r_cpu];
    assign o_sts.scan_hit  = (r_scan != r_cpu) && r_nonempty[r_scan];
    assign o_sts.scan_last = (r_scan == CW'(CPU_COUNT - 1));
    assign o_sts.free_ok   = r_ok && w_in_range;

    assign o_valid           = r_valid;
    assign o_granted_address = r_granted;
    assign o_status          = r_status;

endmodule

### rtl/per_cpu_page_free_list_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_top
// Page allocator with one LIFO free list per CPU and stealing on empty.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on o_granted_address/o_status for exactly one cycle with o_valid,
// and must be captured then, as o_valid is not held. Every request keeps
// busy high until its result is out, so no new request is taken before
// then. When the own list is empty the other CPUs are scanned one per cycle
// in ascending order. The time a request takes is set by that scan and by
// the registered reads of the list-head and link memories. The link memory
// holds no reset state, so requests are taken straight out of reset.
// Registers: pool_base at 0x0, pool_top at 0x4; PAGE_BYTES is a power of two.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator_top #(
    parameter int CPU_COUNT  = pcpa_pkg::CPU_COUNT_DEF,
    parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [pcpa_pkg::CPU_IN_W-1:0]   i_requester_cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]     i_page_address,
    // result channel
    output logic                            o_valid,
    output logic [pcpa_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [pcpa_pkg::STATUS_W-1:0]   o_status,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcpa_pkg::PADDR_W-1:0]    paddr,
    input  logic [pcpa_pkg::ADDR_W-1:0]     pwdata,
    output logic [pcpa_pkg::ADDR_W-1:0]     prdata,
    output logic                            pready
);

    import pcpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_cfg_we;

    // Register port: word index from the address
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    pcpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    pcpa_dp #(
        .CPU_COUNT  (CPU_COUNT),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_func            (i_func),
        .i_requester_cpu   (i_requester_cpu),
        .i_page_address    (i_page_address),
        .i_cfg_we          (w_cfg_we),
        .i_cfg_addr        (paddr[2]),
        .i_cfg_wdata       (pwdata),
        .o_cfg_rdata       (prdata),
        .o_valid           (o_valid),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );

    // Result strobe only once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("request not held after accept");

    // No address goes with a result that grants no page
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FREED || o_status == ST_BADFREE
                     || o_status == ST_OOM)) |-> (o_granted_address == '0))
        else $error("address given without a grant");

    // Memory pops and pushes never coincide
    a_pop_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.pop_wr && w_cmd.push_wr))
        else $error("pop and push in one cycle");

endmodule

### tb/sv/page_grant_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_grant_checker
// Watches the request, result and register channels of the per-CPU page
// allocator. Keeps its own copy of the pool window, the per-CPU list heads
// and the page link table, works out the grant for every accepted request
// and compares each result, field by field, with the oldest one pending.
// ----------------------------------------------------------------------------
module page_grant_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_func,
    input  logic [2:0]  i_cpu,
    input  logic [31:0] i_page_address,
    // result channel
    input  logic        i_res_valid,
    input  logic [31:0] i_granted_address,
    input  logic [2:0]  i_status,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    // to the testbench top
    output int          o_pending,
    output int          o_errors
);
    import pcpa_pkg::*;

    localparam int CPU_COUNT  = CPU_COUNT_DEF;
    localparam int MAX_PAGES  = MAX_PAGES_DEF;
    localparam int PAGE_BYTES = PAGE_BYTES_DEF;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  status;
    } t_grant;

    // shadow of the allocator: window registers, heads and links (index + 1)
    logic [31:0] pool_base_q;
    logic [31:0] pool_top_q;
    logic [15:0] head_tab [CPU_COUNT];
    logic [15:0] link_tab [MAX_PAGES];
    t_grant      expected_grants [$];

    // Serve one request against the shadow lists and return its result
    function automatic t_grant serve_request(input logic func, input logic [2:0] cpu_field,
                                             input logic [31:0] pa);
        logic [32:0] first_pg;
        logic [32:0] pg_off;
        int unsigned cpu;
        int unsigned victim;
        int unsigned idx;
        t_grant      g;
        // base rounded up to a page; bit 32 set means the pool is empty
        first_pg = ({1'b0, pool_base_q} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
        cpu      = cpu_field % CPU_COUNT;
        victim   = 0;
        g.addr   = '0;
        if (func == FUNC_FREE) begin
            g.status = ST_BADFREE;
            if (!first_pg[32] && (pa % PAGE_BYTES) == 0 && pa >= pool_base_q &&
                pa < pool_top_q && {1'b0, pa} >= first_pg) begin
                pg_off = ({1'b0, pa} - first_pg) / PAGE_BYTES;
                if (pg_off < MAX_PAGES) begin
                    link_tab[pg_off] = head_tab[cpu];
                    head_tab[cpu]    = 16'(pg_off + 1);
                    g.status         = ST_FREED;
                end
            end
        end else begin
            g.status = ST_OOM;
            if (head_tab[cpu] != 0) begin
                victim   = cpu;
                g.status = ST_OWN;
            end else begin
                // steal from the lowest-numbered other CPU with a page
                for (int c = 0; c < CPU_COUNT; c++) begin
                    if (g.status == ST_OOM && c != cpu && head_tab[c] != 0) begin
                        victim   = c;
                        g.status = ST_STOLEN;
                    end
                end
            end
            if (g.status != ST_OOM) begin
                idx              = head_tab[victim] - 1;
                head_tab[victim] = link_tab[idx];
                g.addr           = 32'(first_pg + 33'(idx) * PAGE_BYTES);
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            pool_base_q = '0;
            pool_top_q  = '0;
            foreach (head_tab[c]) head_tab[c] = '0;
            expected_grants.delete();
            o_pending <= 0;
            o_errors   = 0;
        end else begin
            // register writes land on the access cycle
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_POOL_BASE)
                    pool_base_q = i_pwdata;
                else
                    pool_top_q = i_pwdata;
            end
            // results first, so a stray one cannot match a request taken this edge
            if (i_res_valid) begin
                if (expected_grants.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result: expected none, actual addr %h status %0d",
                             $time, i_granted_address, i_status);
                end else begin
                    want = expected_grants.pop_front();
                    if (i_granted_address !== want.addr) begin
                        o_errors++;
                        $display("%0t: granted_address mismatch: expected %h actual %h",
                                 $time, want.addr, i_granted_address);
                    end
                    if (i_status !== want.status) begin
                        o_errors++;
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_status);
                    end
                end
            end
            if (i_start && !i_busy)
                expected_grants.push_back(serve_request(i_func, i_cpu, i_page_address));
            o_pending <= expected_grants.size();
        end
    end

endmodule

### tb/sv/tb_per_cpu_page_free_list_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator_top
// Drives the per-CPU page allocator through several pool windows: a short
// directed run over the corner cases, then free-range seeding and random
// alloc/free traffic of pages the test actually holds, with bad frees mixed
// in. Every phase but the last ends by draining all lists to out of memory,
// bar one that moves the pool while pages are still listed. Checking is done by
// page_grant_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_per_cpu_page_free_list_allocator_top;
    import pcpa_pkg::*;

    localparam int PAGE_BYTES     = PAGE_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [2:0]  i_requester_cpu;
    logic [31:0] i_page_address;
    logic        o_valid;
    logic [31:0] o_granted_address;
    logic [2:0]  o_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          errors;
    int          idle_cycles;
    logic [2:0]  last_status;
    logic [31:0] held_pages [$];

    per_cpu_page_free_list_allocator_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_requester_cpu   (i_requester_cpu),
        .i_page_address    (i_page_address),
        .o_valid           (o_valid),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    page_grant_checker chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_func            (i_func),
        .i_cpu             (i_requester_cpu),
        .i_page_address    (i_page_address),
        .i_res_valid       (o_valid),
        .i_granted_address (o_granted_address),
        .i_status          (o_status),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_pending         (pending),
        .o_errors          (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pages handed out are kept so that later frees return real pages;
    // sampled mid-cycle, away from the edges where stimulus runs
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            last_status = o_status;
            if (o_status == ST_OWN || o_status == ST_STOLEN)
                held_pages.push_back(o_granted_address);
        end
    end

    // Watchdog: too long with no request, result or register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly short gaps, some none, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 35)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 6);
        else if (r < 96)
            return $urandom_range(7, 15);
        return $urandom_range(30, 80);
    endfunction

    // Present one request, hold it until taken, then optionally back off
    task automatic issue(input logic func, input logic [2:0] cpu, input logic [31:0] pa,
                         input int gap);
        start           <= 1'b1;
        i_func          <= func;
        i_requester_cpu <= cpu;
        i_page_address  <= pa;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every result is in and the block is idle
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Seed the lists with consecutive pages spread over random CPUs
    task automatic free_span(input logic [31:0] first, input int count);
        for (int k = 0; k < count; k++)
            issue(FUNC_FREE, 3'($urandom), first + 32'(k * PAGE_BYTES), pick_gap(1'b0));
    endtask

    // Allocate until out of memory, so the next window starts with empty lists
    task automatic drain_lists();
        int n;
        n = 0;
        do begin
            issue(FUNC_ALLOC, 3'($urandom), $urandom, 1);
            settle();
            n++;
        end while (last_status != ST_OOM && n < 400);
        held_pages.delete();
    endtask

    // Random alloc/free traffic; valid frees only return held pages, noise
    // frees are kept off the window so no page is pushed twice
    task automatic run_traffic(input logic [31:0] lo, input int pages, input int n_items);
        int          alloc_pct;
        int          r;
        int          pick;
        int          off;
        bit          calm;
        logic [31:0] a;
        logic [31:0] rel;
        alloc_pct = 50;
        calm      = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                alloc_pct = 20 + 30 * $urandom_range(0, 2);
                calm      = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < alloc_pct) begin
                issue(FUNC_ALLOC, 3'($urandom), $urandom, pick_gap(calm));
            end else if (r < 92 && held_pages.size() != 0) begin
                pick = $urandom_range(0, held_pages.size() - 1);
                a    = held_pages[pick];
                held_pages.delete(pick);
                issue(FUNC_FREE, 3'($urandom), a, pick_gap(calm));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        a = $urandom;
                    end
                    1: begin
                        // aligned, around both ends of the window
                        off = int'($urandom_range(0, pages + 15)) - 8;
                        a   = lo + 32'(off * PAGE_BYTES);
                    end
                    2: begin
                        a = lo + 32'($urandom_range(0, pages) * PAGE_BYTES) +
                            32'($urandom_range(1, PAGE_BYTES - 1));
                    end
                    default: begin
                        a = $urandom & ~32'(PAGE_BYTES - 1);
                    end
                endcase
                rel = a - lo;
                if ((a % PAGE_BYTES) == 0 && rel / PAGE_BYTES < pages)
                    a = a + 32'($urandom_range(1, PAGE_BYTES - 1));
                issue(FUNC_FREE, 3'($urandom), a, pick_gap(calm));
            end
            if ($urandom_range(0, 49) == 0)
                settle();
        end
        settle();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_func          <= FUNC_FREE;
        i_requester_cpu <= '0;
        i_page_address  <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window is empty: nothing to give, nothing accepted
        issue(FUNC_ALLOC, 3'd0, 32'h0000_0000, pick_gap(1'b0));
        issue(FUNC_FREE, 3'd7, 32'h0000_0000, pick_gap(1'b0));
        settle();

        // top below base
        reg_write(REG_POOL_TOP, 32'h1000_0000);
        reg_write(REG_POOL_BASE, 32'h2000_0000);
        issue(FUNC_FREE, 3'd0, 32'h2000_0000, pick_gap(1'b0));
        settle();

        // 64-page window, base not aligned so the first page rounds up
        reg_write(REG_POOL_BASE, 32'h1000_0801);
        reg_write(REG_POOL_TOP, 32'h1004_1000);
        issue(FUNC_FREE, 3'd3, 32'h1000_0000, pick_gap(1'b0));   // below base
        issue(FUNC_FREE, 3'd3, 32'h1000_1000, pick_gap(1'b0));   // first page
        issue(FUNC_FREE, 3'd3, 32'h1000_1004, pick_gap(1'b0));   // misaligned
        issue(FUNC_FREE, 3'd3, 32'h1004_1000, pick_gap(1'b0));   // at top
        issue(FUNC_FREE, 3'd3, 32'h1004_0000, pick_gap(1'b0));   // last page
        issue(FUNC_FREE, 3'd5, 32'h1000_5000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd3, 32'hFFFF_FFFF, pick_gap(1'b0));  // own list
        issue(FUNC_ALLOC, 3'd0, 32'h0000_0000, pick_gap(1'b0));  // steal from 3
        issue(FUNC_ALLOC, 3'd0, 32'h0000_0000, pick_gap(1'b0));  // steal from 5
        // double free, then a third push elsewhere breaks the loop it made
        issue(FUNC_FREE, 3'd1, 32'h1000_2000, pick_gap(1'b0));
        issue(FUNC_FREE, 3'd1, 32'h1000_2000, pick_gap(1'b0));
        issue(FUNC_FREE, 3'd2, 32'h1000_2000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd1, 32'h0000_0000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd1, 32'h0000_0000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd6, 32'h0000_0000, pick_gap(1'b0));  // out of memory
        settle();
        held_pages.delete();
        free_span(32'h1000_1000, 64);
        run_traffic(32'h1000_1000, 64, 450);
        drain_lists();

        // whole address space: only the first MAX_PAGES pages are usable
        reg_write(REG_POOL_BASE, 32'h0000_0000);
        reg_write(REG_POOL_TOP, 32'hFFFF_FFFF);
        issue(FUNC_FREE, 3'd2, 32'h0800_0000, pick_gap(1'b0));   // page index too big
        issue(FUNC_FREE, 3'd2, 32'h07FF_F000, pick_gap(1'b0));
        issue(FUNC_FREE, 3'd6, 32'h0000_0000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd7, 32'h0000_0000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd6, 32'h0000_0000, pick_gap(1'b0));
        settle();
        held_pages.delete();
        free_span(32'h0000_0000, 16);
        free_span(32'h07FF_0000, 16);
        run_traffic(32'h0000_0000, MAX_PAGES_DEF, 400);
        drain_lists();

        // single page at the very top of memory
        reg_write(REG_POOL_BASE, 32'hFFFF_F000);
        issue(FUNC_FREE, 3'd1, 32'hFFFF_F000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd7, 32'h0000_0000, pick_gap(1'b0));
        settle();
        held_pages.delete();
        free_span(32'hFFFF_F000, 1);
        run_traffic(32'hFFFF_F000, 1, 150);
        drain_lists();

        // 33 pages across the 2 GiB line; left listed for the next window
        reg_write(REG_POOL_BASE, 32'h7FFF_F000);
        reg_write(REG_POOL_TOP, 32'h8002_0000);
        free_span(32'h7FFF_F000, 33);
        run_traffic(32'h7FFF_F000, 33, 200);
        held_pages.delete();

        // base rounds up past the top of memory: frees all fail, pages
        // still listed come back at wrapped addresses
        reg_write(REG_POOL_BASE, 32'hFFFF_F001);
        issue(FUNC_FREE, 3'd4, 32'hFFFF_F000, pick_gap(1'b0));
        issue(FUNC_ALLOC, 3'd3, 32'h0000_0000, pick_gap(1'b0));
        run_traffic(32'h0000_0000, 0, 100);
        drain_lists();

        // low 64-page window
        reg_write(REG_POOL_BASE, 32'h0000_0000);
        reg_write(REG_POOL_TOP, 32'h0004_0000);
        free_span(32'h0000_0000, 64);
        run_traffic(32'h0000_0000, 64, 300);

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### per_cpu_page_free_list_allocator_top.f
rtl/pcpa_pkg.sv
rtl/pcpa_ram.sv
rtl/pcpa_ctrl.sv
rtl/pcpa_dp.sv
rtl/per_cpu_page_free_list_allocator_top.sv
tb/sv/page_grant_checker.sv
tb/sv/tb_per_cpu_page_free_list_allocator_top.sv
